// ===== src/bfa_pkg.sv =====
// bfa_pkg: shared types and constants for the bitmap frame allocator.
// No dependencies.
`default_nettype none
package bfa_pkg;

   localparam int NUM_FRAMES_DEF = 65536;
   localparam int WORD_BITS_DEF  = 64;

   // frame index wide enough for pointer+1 and candidate+count
   localparam int FRAME_W = 18;
   localparam int COUNT_W = 17;

   localparam logic [1:0] MODE_ALLOC   = 2'd0;
   localparam logic [1:0] MODE_CHECKED = 2'd1;
   localparam logic [1:0] MODE_SINGLE  = 2'd2;
   localparam logic [1:0] MODE_MARK    = 2'd3;

   localparam logic [2:0] STAT_OK       = 3'd0;
   localparam logic [2:0] STAT_OOM      = 3'd1;
   localparam logic [2:0] STAT_RANGE    = 3'd2;
   localparam logic [2:0] STAT_ALREADY  = 3'd3;
   localparam logic [2:0] STAT_BADCOUNT = 3'd4;
   localparam logic [2:0] STAT_UNALLOC  = 3'd5;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] start_frame;
      logic [16:0] frame_count;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] alloc_frame;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ASCAN,
      ST_CCHECK,
      ST_SINGLE,
      ST_WRITE,
      ST_LOAD,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

// ===== src/bfa_ram.sv =====
// bfa_ram: generic single-clock RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module bfa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

// ===== src/bitmap_frame_allocator.sv =====
// bitmap_frame_allocator: next-fit bitmap frame allocator, top level.
// Depends on bfa_pkg and bfa_ram.
//
//   channel | direction | payload          | transfer when
//   req     | in        | req_type         | req_valid & req_ready
//   rsp     | out       | rsp_type         | rsp_valid & rsp_ready
//   csr     | in        | last_frame 16b   | csr_valid & csr_ready
//
// After reset a clearing pass writes all ones into the bitmap, with req_ready
// low. An item is accepted in IDLE and answered from DONE, and walks its frames
// one per cycle through a one-word buffer, save that each buffer miss stalls it
// in LOAD (write-back plus read). Allocate probes candidates, then writes count
// frames; frees write count frames (checked first when checked); single free: one.
// A finished result sits in the output register and the next item is taken
// meanwhile; the following result waits in DONE until that register drains.
`default_nettype none
module bitmap_frame_allocator
   import bfa_pkg::*;
#(
   parameter int NUM_FRAMES = NUM_FRAMES_DEF,
   parameter int WORD_BITS  = WORD_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data
);

   localparam int MAP_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BW = $clog2(WORD_BITS);

   state_type st_ff, st_in, ret_ff, ret_in;
   logic [FRAME_W-1:0]   base_ff, base_in;
   logic [COUNT_W-1:0]   off_ff, off_in, cnt_ff, cnt_in;
   logic [1:0]           mode_ff, mode_in;
   logic                 wval_ff, wval_in;
   logic [15:0]          ptr_ff, ptr_in, last_ff, last_in, where_ff, where_in;
   logic [2:0]           stat_ff, stat_in;
   logic [WORD_BITS-1:0] buf_ff, buf_in;
   logic [AW-1:0]        baddr_ff, baddr_in, clr_ff, clr_in;
   logic                 bvalid_ff, bvalid_in, bdirty_ff, bdirty_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 mem_we;
   logic [AW-1:0]        mem_waddr, mem_raddr;
   logic [WORD_BITS-1:0] mem_wdata, mem_rdata;

   logic [FRAME_W-1:0]   f;
   logic [AW-1:0]        f_word;
   logic [BW-1:0]        f_bit;
   logic                 in_map, hit, fbit, past_last;

   assign f         = base_ff + FRAME_W'(off_ff);
   assign f_word    = AW'(f / WORD_BITS);
   assign f_bit     = BW'(f % WORD_BITS);
   assign in_map    = (32'(f) < NUM_FRAMES);
   assign hit       = bvalid_ff && (baddr_ff == f_word);
   assign fbit      = buf_ff[f_bit];
   assign past_last = (f > FRAME_W'(last_ff));

   assign req_ready = (st_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   bfa_ram #(.WIDTH(WORD_BITS), .DEPTH(MAP_WORDS), .AW(AW)) u_map (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(MAP_WORDS - 1)) st_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_data.mode)
                  MODE_ALLOC:
                     st_in = (req_data.frame_count == '0) ? ST_DONE : ST_ASCAN;
                  MODE_CHECKED: begin
                     if ((FRAME_W'(req_data.start_frame) + FRAME_W'(req_data.frame_count))
                         > FRAME_W'(last_ff) || req_data.frame_count == '0)
                        st_in = ST_DONE;
                     else
                        st_in = ST_CCHECK;
                  end
                  MODE_SINGLE:
                     st_in = ST_SINGLE;
                  MODE_MARK:
                     st_in = (req_data.frame_count == '0) ? ST_DONE : ST_WRITE;
                  default: st_in = ST_IDLE;
               endcase
            end
         end
         ST_ASCAN: begin
            if (off_ff == '0 && past_last) st_in = ST_DONE;
            else if (!past_last && in_map && !hit) st_in = ST_LOAD;
            else if (!(past_last || !in_map || fbit) && off_ff + COUNT_W'(1) == cnt_ff)
               st_in = ST_WRITE;
         end
         ST_CCHECK: begin
            if (off_ff == cnt_ff) st_in = ST_WRITE;
            else if (in_map && !hit) st_in = ST_LOAD;
            else if (in_map && !fbit) st_in = ST_DONE;
         end
         ST_SINGLE: begin
            if (in_map && !hit) st_in = ST_LOAD;
            else st_in = ST_DONE;
         end
         ST_WRITE: begin
            if (off_ff == cnt_ff || !in_map) st_in = ST_DONE;
            else if (!hit) st_in = ST_LOAD;
            else if (off_ff + COUNT_W'(1) == cnt_ff) st_in = ST_DONE;
         end
         ST_LOAD:
            st_in = ret_ff;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      ret_in       = ret_ff;
      base_in      = base_ff;
      off_in       = off_ff;
      cnt_in       = cnt_ff;
      mode_in      = mode_ff;
      wval_in      = wval_ff;
      ptr_in       = ptr_ff;
      last_in      = last_ff;
      where_in     = where_ff;
      stat_in      = stat_ff;
      buf_in       = buf_ff;
      baddr_in     = baddr_ff;
      bvalid_in    = bvalid_ff;
      bdirty_in    = bdirty_ff;
      clr_in       = clr_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_we       = 1'b0;
      mem_waddr    = baddr_ff;
      mem_wdata    = buf_ff;
      mem_raddr    = f_word;

      if (csr_valid) last_in = csr_data;

      // on a miss: write back a dirty buffer and fetch the word of f together
      if (st_in == ST_LOAD && st_ff != ST_LOAD) begin
         ret_in = st_ff;
         mem_we = bvalid_ff && bdirty_ff;
      end

      unique case (st_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '1;
            clr_in    = clr_ff + AW'(1);
         end
         ST_IDLE: begin
            if (req_valid) begin
               mode_in  = req_data.mode;
               cnt_in   = req_data.frame_count;
               off_in   = '0;
               where_in = '0;
               stat_in  = STAT_OK;
               base_in  = FRAME_W'(req_data.start_frame);
               wval_in  = 1'b0;
               unique case (req_data.mode)
                  MODE_ALLOC: begin
                     base_in = FRAME_W'(ptr_ff) + FRAME_W'(1);
                     if (req_data.frame_count == '0) stat_in = STAT_BADCOUNT;
                  end
                  MODE_CHECKED: begin
                     if ((FRAME_W'(req_data.start_frame) + FRAME_W'(req_data.frame_count))
                         > FRAME_W'(last_ff))
                        stat_in = STAT_RANGE;
                     else if (req_data.frame_count == '0)
                        ptr_in = '0;
                  end
                  MODE_MARK: begin
                     if (req_data.frame_count == '0) ptr_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_ASCAN: begin
            if (off_ff == '0 && past_last) begin
               stat_in = STAT_OOM;
            end else if (!past_last && in_map && !hit) begin
            end else if (past_last || !in_map || fbit) begin
               // a candidate that fails past its first frame skips count-1 further frames
               if (off_ff == '0) base_in = base_ff + FRAME_W'(1);
               else base_in = base_ff + FRAME_W'(cnt_ff);
               off_in = '0;
            end else if (off_ff + COUNT_W'(1) == cnt_ff) begin
               off_in  = '0;
               wval_in = 1'b1;
            end else begin
               off_in = off_ff + COUNT_W'(1);
            end
         end
         ST_CCHECK: begin
            if (off_ff == cnt_ff) begin
               off_in  = '0;
               wval_in = 1'b0;
            end else if (!in_map) begin
               off_in = off_ff + COUNT_W'(1);
            end else if (hit) begin
               if (!fbit) stat_in = STAT_ALREADY;
               else off_in = off_ff + COUNT_W'(1);
            end
         end
         ST_SINGLE: begin
            if (!in_map) begin
               ptr_in = '0;
            end else if (hit) begin
               if (!fbit) stat_in = STAT_UNALLOC;
               buf_in[f_bit] = 1'b0;
               bdirty_in     = 1'b1;
               ptr_in        = '0;
            end
         end
         ST_WRITE: begin
            if (off_ff != cnt_ff && in_map && hit) begin
               buf_in[f_bit] = wval_ff;
               bdirty_in     = 1'b1;
               off_in        = off_ff + COUNT_W'(1);
            end
            if (st_in == ST_DONE) begin
               if (mode_ff == MODE_ALLOC) begin
                  where_in = base_ff[15:0];
                  ptr_in   = 16'(base_ff + FRAME_W'(cnt_ff) - FRAME_W'(1));
               end else begin
                  ptr_in = '0;
               end
            end
         end
         ST_LOAD: begin
            buf_in    = mem_rdata;
            baddr_in  = f_word;
            bvalid_in = 1'b1;
            bdirty_in = 1'b0;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = stat_ff;
               rsp_in.alloc_frame = where_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_CLEAR;
         ret_ff       <= ST_IDLE;
         clr_ff       <= '0;
         bvalid_ff    <= 1'b0;
         bdirty_ff    <= 1'b0;
         ptr_ff       <= '0;
         last_ff      <= 16'hFFFF;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         ret_ff       <= ret_in;
         clr_ff       <= clr_in;
         bvalid_ff    <= bvalid_in;
         bdirty_ff    <= bdirty_in;
         ptr_ff       <= ptr_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff  <= base_in;
      off_ff   <= off_in;
      cnt_ff   <= cnt_in;
      mode_ff  <= mode_in;
      wval_ff  <= wval_in;
      where_ff <= where_in;
      stat_ff  <= stat_in;
      buf_ff   <= buf_in;
      baddr_ff <= baddr_in;
      rsp_ff   <= rsp_in;
   end

endmodule
`default_nettype wire

// ===== test/tb_bitmap_frame_allocator.sv =====
// tb_bitmap_frame_allocator: self-checking testbench for the next-fit bitmap frame allocator.
// Depends on bfa_pkg and bitmap_frame_allocator; holds its own bitmap predictor and a result checker.
`timescale 1ns / 1ps
module tb_bitmap_frame_allocator
   import bfa_pkg::*;
();

   localparam int FRAMES     = 65536;
   localparam int IDLE_LIMIT = 1000000;

   typedef struct {
      int first;
      int len;
   } run_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   // predictor state
   bit [FRAMES-1:0] frame_busy = '1;
   int              fit_ptr = 0;
   int              top_frame = 65535;

   rsp_type expected_rsp[$];
   run_type held_runs[$];
   int      errors = 0;
   int      n_items = 0;
   int      n_ok_allocs = 0;
   int      n_oom = 0;
   int      n_phases = 0;
   int      idle_cycles = 0;
   bit      no_gaps = 1'b0;
   int      ready_hold = 0;

   bitmap_frame_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic bit search_busy(int f);
      return f > top_frame || f >= FRAMES || frame_busy[f];
   endfunction

   // next-fit search, frees and region marking; updates the predictor state
   function automatic rsp_type predict_frame_op(req_type r);
      int      c;
      int      i;
      int      cnt;
      int      st;
      bit      fits;
      rsp_type o;
      cnt = r.frame_count;
      st  = r.start_frame;
      o.status = STAT_OK;
      o.alloc_frame = '0;
      case (r.mode)
         MODE_ALLOC: begin
            if (cnt == 0) begin
               o.status = STAT_BADCOUNT;
            end else begin
               o.status = STAT_OOM;
               for (c = fit_ptr + 1; c <= top_frame; c++) begin
                  if (search_busy(c)) continue;
                  fits = 1'b1;
                  for (i = 1; i < cnt; i++) begin
                     if (search_busy(c + i)) begin
                        fits = 1'b0;
                        break;
                     end
                  end
                  if (!fits) begin
                     c += cnt - 1;   // skip the rest of the failed candidate
                     continue;
                  end
                  for (i = 0; i < cnt; i++)
                     if (c + i < FRAMES) frame_busy[c + i] = 1'b1;
                  o.status = STAT_OK;
                  o.alloc_frame = c[15:0];
                  fit_ptr = (c + cnt - 1) & 16'hFFFF;
                  break;
               end
            end
         end
         MODE_CHECKED: begin
            if (st + cnt > top_frame) begin
               o.status = STAT_RANGE;
            end else begin
               for (i = 0; i < cnt; i++) begin
                  if (st + i >= FRAMES || !frame_busy[st + i]) ;
                  else continue;
                  if (st + i < FRAMES) begin
                     o.status = STAT_ALREADY;
                     break;
                  end
               end
               if (o.status == STAT_OK) begin
                  for (i = 0; i < cnt; i++)
                     if (st + i < FRAMES) frame_busy[st + i] = 1'b0;
                  fit_ptr = 0;
               end
            end
         end
         MODE_SINGLE: begin
            if (!frame_busy[st]) o.status = STAT_UNALLOC;
            frame_busy[st] = 1'b0;
            fit_ptr = 0;
         end
         default: begin
            for (i = 0; i < cnt; i++) begin
               if (st + i >= FRAMES) break;
               frame_busy[st + i] = 1'b0;
            end
            fit_ptr = 0;
         end
      endcase
      return o;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   task automatic send_item(logic [1:0] mode, int start, int count);
      req_type r;
      rsp_type p;
      int      gap;
      int      pick;
      r.mode = mode;
      r.start_frame = start[15:0];
      r.frame_count = count[16:0];
      pick = $urandom_range(0, 99);
      if (no_gaps || pick < 50) gap = 0;
      else if (pick < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 80);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      p = predict_frame_op(r);
      expected_rsp.push_back(p);
      n_items++;
      if (mode == MODE_ALLOC && p.status == STAT_OK) begin
         held_runs.push_back('{first: p.alloc_frame, len: count});
         n_ok_allocs++;
      end
      if (mode == MODE_ALLOC && p.status == STAT_OOM) n_oom++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_last_frame(int value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= value[15:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      top_frame = value & 16'hFFFF;
      n_phases++;
   endtask

   // extremes of every field on the fully used map left by reset
   task automatic test_directed_edges();
      no_gaps = 1'b1;
      send_item(MODE_ALLOC, 0, 0);           // zero count rejected
      send_item(MODE_ALLOC, 16'hFFFF, 1);    // whole map used: out of memory
      send_item(MODE_CHECKED, 1, 65535);     // run ends past last frame
      send_item(MODE_MARK, 16'hFFFF, 65536); // clipped at the end of the map
      send_item(MODE_SINGLE, 16'hFFFF, 0);   // frame already free
      send_item(MODE_SINGLE, 0, 65536);
      send_item(MODE_CHECKED, 100, 0);       // empty run still succeeds
      send_item(MODE_MARK, 0, 16);
      send_item(MODE_ALLOC, 0, 4);
      send_item(MODE_ALLOC, 0, 65536);       // too long to fit anywhere
      send_item(MODE_CHECKED, 1, 4);
      send_item(MODE_CHECKED, 1, 4);         // second free finds frames free
      send_item(MODE_ALLOC, 0, 1);
      send_item(MODE_MARK, 16'hAAAA, 16'h5555);
      send_item(MODE_ALLOC, 0, 3);
      send_item(MODE_CHECKED, 16'h5555, 16'hAAAA);
      no_gaps = 1'b0;
      write_last_frame(0);
      send_item(MODE_ALLOC, 0, 1);
      send_item(MODE_CHECKED, 0, 0);
      send_item(MODE_CHECKED, 0, 1);
      send_item(MODE_SINGLE, 0, 0);
   endtask

   // mostly allocate and free sequences inside 0..last_frame, some noise
   task automatic test_random_phase(int limit, int items);
      int      k;
      int      pick;
      int      idx;
      run_type rr;
      write_last_frame(limit);
      held_runs.delete();
      send_item(MODE_MARK, 0, limit < 200 ? limit + 1 : 200);
      for (k = 0; k < items; k++) begin
         if (k % 300 == 150) no_gaps = ~no_gaps;
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            send_item(MODE_ALLOC, $urandom, $urandom_range(0, 9) == 0 ?
                      $urandom_range(0, 16) : $urandom_range(1, 4));
         end else if (pick < 55 && held_runs.size() != 0) begin
            idx = $urandom_range(0, held_runs.size() - 1);
            rr = held_runs[idx];
            held_runs.delete(idx);
            send_item(MODE_CHECKED, rr.first, rr.len);
         end else if (pick < 65) begin
            if (held_runs.size() != 0 && pick < 61) begin
               idx = $urandom_range(0, held_runs.size() - 1);
               send_item(MODE_SINGLE, held_runs[idx].first, $urandom);
               held_runs.delete(idx);
            end else begin
               send_item(MODE_SINGLE, $urandom_range(0, limit), $urandom);
            end
         end else if (pick < 80) begin
            send_item(MODE_MARK, $urandom_range(0, limit), $urandom_range(1, 32));
         end else if (pick < 90) begin
            send_item(MODE_CHECKED, $urandom_range(0, limit), $urandom_range(0, 8));
         end else begin
            send_item(2'($urandom_range(0, 3)), $urandom, $urandom_range(0, 3));
         end
      end
   endtask

   task automatic test_drain_pause();
      wait_drained();
      send_item(MODE_ALLOC, 0, 2);
   endtask

   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
               rsp_ready  <= 1'b1;
               ready_hold <= $urandom_range(0, 25);
            end
            19: begin
               rsp_ready  <= 1'b0;
               ready_hold <= $urandom_range(20, 150);
            end
            default: begin
               rsp_ready  <= 1'b0;
               ready_hold <= $urandom_range(0, 3);
            end
         endcase
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (rsp_valid && rsp_ready && !reset) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected result, status", rsp_data.status, -1);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", rsp_data.status, want.status);
            if (rsp_data.alloc_frame !== want.alloc_frame)
               report_mismatch("alloc_frame", rsp_data.alloc_frame, want.alloc_frame);
         end
      end
   end

   // watchdog: ends the run when no channel has moved a transfer for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_edges();
      test_random_phase(255, 600);
      test_drain_pause();
      test_random_phase(63, 350);
      test_random_phase(1023, 550);
      test_random_phase(0, 40);
      test_random_phase(4095, 300);
      test_random_phase(65535, 120);
      wait_drained();
      repeat (200) @(posedge clock);
      $display("covered %0d items over %0d last_frame settings", n_items, n_phases);
      $display("%0d allocations granted, %0d out of memory", n_ok_allocs, n_oom);
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         if (expected_rsp.size() != 0)
            $display("%0d results never arrived", expected_rsp.size());
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/bfa_pkg.sv
src/bfa_ram.sv
src/bitmap_frame_allocator.sv
test/tb_bitmap_frame_allocator.sv
